### rtl/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising clk edge outside reset
`define AST_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// implication checked on every rising clk edge outside reset
`define AST_IMP(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) else $error(msg);

`endif

### rtl/rau_pkg.sv
// package with widths and codes for the rational arithmetic unit
package rau_pkg;

  localparam int FIELD_W           = 32;
  localparam int RES_W             = 64;
  localparam int DEN_W             = 63;
  localparam int OPERAND_WIDTH_DEF = 32;
  localparam int STATUS_W          = 2;

  typedef enum logic [2:0] {
    OP_NORM = 3'd0,
    OP_ADD  = 3'd1,
    OP_SUB  = 3'd2,
    OP_MUL  = 3'd3,
    OP_DIV  = 3'd4,
    OP_NEG  = 3'd5,
    OP_ABS  = 3'd6,
    OP_CMP  = 3'd7
  } op_t;

  localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
  localparam logic [STATUS_W-1:0] ST_ZDEN = 2'd1;
  localparam logic [STATUS_W-1:0] ST_OVF  = 2'd2;

endpackage

### rtl/rational_arithmetic_unit.sv
// rational arithmetic unit: fraction ops with gcd reduction on a shared datapath
//
// input channel in_* (valid/ready) carries op and fractions A, B; result channel
// out_* (valid/ready) carries one result item per input item.
// an item runs through a sequencer: three multiply steps on a shared 32x32
// multiplier, an add/compare step, a binary gcd loop (one step per cycle, then a
// finish step), then a restoring divider that divides numerator and denominator
// by the gcd, first the numerator and then the denominator. error items go
// straight to the final state, and compares skip the gcd loop and the divider.
// in_ready is high only while the sequencer is idle, so one item is in work at
// a time; the next item is taken only after the last one leaves the final state.
// the result sits in an output register; a new item is accepted while it waits,
// and a stalled receiver only holds the next item in its final state.
// rst_n (synchronous, active low) returns the sequencer to idle and drops
// out_valid; no other clearing is needed.
module rational_arithmetic_unit import rau_pkg::*; #(
  parameter int OPERAND_WIDTH = OPERAND_WIDTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [2:0]          in_op,
  input  logic [FIELD_W-1:0]  in_a_num,
  input  logic [FIELD_W-1:0]  in_a_den,
  input  logic [FIELD_W-1:0]  in_b_num,
  input  logic [FIELD_W-1:0]  in_b_den,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [RES_W-1:0]    out_res_num,
  output logic [DEN_W-1:0]    out_res_den,
  output logic                out_a_less_b,
  output logic                out_a_equal_b,
  output logic [STATUS_W-1:0] out_status
);

  localparam int W = OPERAND_WIDTH;

  typedef enum logic [3:0] {
    S_IDLE, S_MUL1, S_MUL2, S_MUL3, S_SUM, S_GCD, S_DIVN, S_DIVD, S_FIN
  } state_t;

  state_t           state_r;
  op_t              op_r;
  logic [W-1:0]     am_r, ad_r, bm_r, bd_r;
  logic             an_r, bn_r, err_r, sgn_r, lt_r, eq_r;
  logic [RES_W-1:0] n1_r, n2_r, d_r, u_r, v_r, g_r, rem_r, q_r, qn_r;
  logic [5:0]       k_r, cnt_r;
  logic             out_valid_r, lt_out_r, eq_out_r;
  logic [RES_W-1:0] num_out_r;
  logic [DEN_W-1:0] den_out_r;
  logic [STATUS_W-1:0] st_out_r;

  // operand decode
  logic [W-1:0] fan, fad, fbn, fbd, man, mad, mbn, mbd;
  logic         is_bin, in_err;
  op_t          in_opc;

  assign in_opc = op_t'(in_op);
  assign fan = in_a_num[W-1:0];
  assign fad = in_a_den[W-1:0];
  assign fbn = in_b_num[W-1:0];
  assign fbd = in_b_den[W-1:0];
  assign man = fan[W-1] ? W'(-fan) : fan;
  assign mad = fad[W-1] ? W'(-fad) : fad;
  assign mbn = fbn[W-1] ? W'(-fbn) : fbn;
  assign mbd = fbd[W-1] ? W'(-fbd) : fbd;
  assign is_bin = (in_opc == OP_ADD) || (in_opc == OP_SUB) || (in_opc == OP_MUL) ||
                  (in_opc == OP_DIV) || (in_opc == OP_CMP);
  assign in_err = (fad == '0) || (is_bin && fbd == '0) ||
                  (in_opc == OP_DIV && fbn == '0);

  // shared multiplier
  logic             unary;
  logic [W-1:0]     mul_x, mul_y;
  logic [2*W-1:0]   prod;
  logic [RES_W-1:0] prod_ext;

  assign unary = (op_r == OP_NORM) || (op_r == OP_NEG) || (op_r == OP_ABS);

  always_comb begin
    case (state_r)
      S_MUL1: begin
        mul_x = am_r;
        mul_y = unary ? W'(1) : (op_r == OP_MUL) ? bm_r : bd_r;
      end
      S_MUL2: begin
        mul_x = bm_r;
        mul_y = ad_r;
      end
      S_MUL3: begin
        mul_x = ad_r;
        mul_y = unary ? W'(1) : (op_r == OP_DIV) ? bm_r : bd_r;
      end
      default: begin
        mul_x = am_r;
        mul_y = bd_r;
      end
    endcase
  end

  assign prod     = mul_x * mul_y;
  assign prod_ext = RES_W'(prod);

  // add stage
  logic             bs, sum_sgn;
  logic [RES_W-1:0] sum_mag, cx, cy;

  always_comb begin
    bs = bn_r ^ (op_r == OP_SUB);
    case (op_r)
      OP_ADD, OP_SUB: begin
        if (an_r == bs) begin
          sum_mag = n1_r + n2_r;
          sum_sgn = an_r;
        end else if (n1_r >= n2_r) begin
          sum_mag = n1_r - n2_r;
          sum_sgn = an_r;
        end else begin
          sum_mag = n2_r - n1_r;
          sum_sgn = bs;
        end
      end
      OP_MUL, OP_DIV: begin
        sum_mag = n1_r;
        sum_sgn = an_r ^ bn_r;
      end
      OP_NEG: begin
        sum_mag = n1_r;
        sum_sgn = ~an_r;
      end
      OP_ABS: begin
        sum_mag = n1_r;
        sum_sgn = 1'b0;
      end
      default: begin
        sum_mag = n1_r;
        sum_sgn = an_r;
      end
    endcase
  end

  assign cx = an_r ? RES_W'(-n1_r) : n1_r;
  assign cy = bn_r ? RES_W'(-n2_r) : n2_r;

  // binary gcd step
  logic             gcd_done;
  logic [RES_W-1:0] u_nxt, v_nxt;
  logic [5:0]       k_nxt;

  assign gcd_done = (u_r == '0);

  always_comb begin
    u_nxt = u_r;
    v_nxt = v_r;
    k_nxt = k_r;
    if (!u_r[0] && !v_r[0]) begin
      u_nxt = u_r >> 1;
      v_nxt = v_r >> 1;
      k_nxt = k_r + 6'd1;
    end else if (!u_r[0]) begin
      u_nxt = u_r >> 1;
    end else if (!v_r[0]) begin
      v_nxt = v_r >> 1;
    end else if (u_r >= v_r) begin
      u_nxt = (u_r - v_r) >> 1;
    end else begin
      v_nxt = (v_r - u_r) >> 1;
    end
  end

  // restoring divider step
  logic [RES_W:0]   div_sh;
  logic             div_ge;
  logic [RES_W-1:0] rem_nxt, q_nxt;

  assign div_sh  = {rem_r, q_r[RES_W-1]};
  assign div_ge  = div_sh >= {1'b0, g_r};
  assign rem_nxt = div_ge ? RES_W'(div_sh - {1'b0, g_r}) : div_sh[RES_W-1:0];
  assign q_nxt   = {q_r[RES_W-2:0], div_ge};

  // final sign and range check
  logic             fin_neg, fin_ovf;
  assign fin_neg = sgn_r && (qn_r != '0);
  assign fin_ovf = q_r[RES_W-1] || (!fin_neg && qn_r[RES_W-1]) ||
                   (fin_neg && qn_r[RES_W-1] && (qn_r[RES_W-2:0] != '0));

  assign in_ready = (state_r == S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      // the final state reloads the output register itself
      if (out_valid_r && out_ready && (state_r != S_FIN)) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            op_r  <= in_opc;
            am_r  <= man;
            ad_r  <= mad;
            bm_r  <= mbn;
            bd_r  <= mbd;
            an_r  <= fan[W-1] ^ fad[W-1];
            bn_r  <= fbn[W-1] ^ fbd[W-1];
            err_r <= in_err;
            state_r <= in_err ? S_FIN : S_MUL1;
          end
        end
        S_MUL1: begin
          n1_r    <= prod_ext;
          state_r <= S_MUL2;
        end
        S_MUL2: begin
          n2_r    <= prod_ext;
          state_r <= S_MUL3;
        end
        S_MUL3: begin
          d_r     <= prod_ext;
          state_r <= S_SUM;
        end
        S_SUM: begin
          lt_r  <= $signed(cx) < $signed(cy);
          eq_r  <= cx == cy;
          n1_r  <= sum_mag;
          sgn_r <= sum_sgn;
          u_r   <= sum_mag;
          v_r   <= d_r;
          k_r   <= '0;
          state_r <= (op_r == OP_CMP) ? S_FIN : S_GCD;
        end
        S_GCD: begin
          if (gcd_done) begin
            g_r     <= v_r << k_r;
            rem_r   <= '0;
            q_r     <= n1_r;
            cnt_r   <= '0;
            state_r <= S_DIVN;
          end else begin
            u_r <= u_nxt;
            v_r <= v_nxt;
            k_r <= k_nxt;
          end
        end
        S_DIVN: begin
          cnt_r <= cnt_r + 6'd1;
          if (cnt_r == '1) begin
            qn_r    <= q_nxt;
            q_r     <= d_r;
            rem_r   <= '0;
            state_r <= S_DIVD;
          end else begin
            q_r   <= q_nxt;
            rem_r <= rem_nxt;
          end
        end
        S_DIVD: begin
          cnt_r <= cnt_r + 6'd1;
          q_r   <= q_nxt;
          rem_r <= rem_nxt;
          if (cnt_r == '1) begin
            state_r <= S_FIN;
          end
        end
        S_FIN: begin
          // wait until the previous result has been taken
          if (!out_valid_r || out_ready) begin
            out_valid_r <= 1'b1;
            if (err_r) begin
              st_out_r  <= ST_ZDEN;
              lt_out_r  <= 1'b0;
              eq_out_r  <= 1'b0;
              num_out_r <= '0;
              den_out_r <= '0;
            end else if (op_r == OP_CMP) begin
              st_out_r  <= ST_OK;
              lt_out_r  <= lt_r;
              eq_out_r  <= eq_r;
              num_out_r <= '0;
              den_out_r <= '0;
            end else if (fin_ovf) begin
              st_out_r  <= ST_OVF;
              lt_out_r  <= 1'b0;
              eq_out_r  <= 1'b0;
              num_out_r <= '0;
              den_out_r <= '0;
            end else begin
              st_out_r  <= ST_OK;
              lt_out_r  <= 1'b0;
              eq_out_r  <= 1'b0;
              num_out_r <= fin_neg ? RES_W'(-qn_r) : qn_r;
              den_out_r <= q_r[DEN_W-1:0];
            end
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid     = out_valid_r;
  assign out_res_num   = num_out_r;
  assign out_res_den   = den_out_r;
  assign out_a_less_b  = lt_out_r;
  assign out_a_equal_b = eq_out_r;
  assign out_status    = st_out_r;

endmodule

### rtl/rau_checker.sv
// port-level checker for the rational arithmetic unit and its bind
`include "assert_macros.svh"
module rau_checker import rau_pkg::*; (
  input logic                clk,
  input logic                rst_n,
  input logic                out_valid,
  input logic                out_ready,
  input logic [RES_W-1:0]    out_res_num,
  input logic [DEN_W-1:0]    out_res_den,
  input logic                out_a_less_b,
  input logic                out_a_equal_b,
  input logic [STATUS_W-1:0] out_status
);

  `AST_CLK(a_hold, out_valid && !out_ready |=> out_valid && $stable(out_res_num), "result dropped while stalled")
  `AST_IMP(a_err_zero, out_valid && out_status != ST_OK, out_res_num == '0 && out_res_den == '0 && !out_a_less_b && !out_a_equal_b, "error item with nonzero fields")
  `AST_IMP(a_cmp_excl, out_valid && out_a_less_b, !out_a_equal_b, "less and equal both set")
  `AST_IMP(a_frac_den, out_valid && (out_a_less_b || out_a_equal_b), out_res_den == '0 && out_res_num == '0, "compare item carries a fraction")
  `AST_IMP(a_ok_den, out_valid && out_status == ST_OK && out_res_num != '0, out_res_den != '0, "nonzero numerator with zero denominator")

endmodule

bind rational_arithmetic_unit rau_checker u_rau_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .out_res_num   (out_res_num),
  .out_res_den   (out_res_den),
  .out_a_less_b  (out_a_less_b),
  .out_a_equal_b (out_a_equal_b),
  .out_status    (out_status)
);
